[design/wcel_pkg.sv]
// shared constants, field layout and controller/datapath interface types
// for the exact-length walk counter; no dependencies
package wcel_pkg;

    localparam int VERTICES  = 16;
    localparam int MAX_WALK  = 15;

    localparam int FIELD_VW  = 4;
    localparam int ROW_W     = 16;
    localparam int CNT_W     = 32;

    localparam int NV        = (VERTICES < ROW_W) ? VERTICES : ROW_W;
    localparam int VW        = (NV > 1) ? $clog2(NV) : 1;
    localparam int MAX_LEN   = (MAX_WALK < (2 ** FIELD_VW) - 1) ? MAX_WALK
                                                                : (2 ** FIELD_VW) - 1;

    localparam int ROW_IDX_LSB = 0;
    localparam int ROW_BITS_LSB = ROW_IDX_LSB + FIELD_VW;
    localparam int FROM_LSB    = ROW_BITS_LSB + ROW_W;
    localparam int TO_LSB      = FROM_LSB + FIELD_VW;
    localparam int LEN_LSB     = TO_LSB + FIELD_VW;
    localparam int S_DATA_W    = LEN_LSB + FIELD_VW;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic          wr_row;
        logic          start;
        logic          step;
        logic          last;
        logic [VW-1:0] idx;
        logic          emit;
    } t_cmd;

    typedef struct packed {
        logic len_zero;
        logic out_free;
    } t_sts;

endpackage

[design/wcel_ctrl.sv]
// sequencer for the walk counter: input handshake, pass and successor counting
// depends on wcel_pkg
module wcel_ctrl
    import wcel_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    input  logic i_s_tuser,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } t_state;

    t_state        r_state;
    logic [VW-1:0] r_idx;
    logic          w_accept;
    logic          w_last;

    assign o_s_tready = (r_state == ST_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_last     = (r_idx == VW'(NV - 1));

    always_comb begin
        o_cmd        = '0;
        o_cmd.idx    = r_idx;
        o_cmd.last   = w_last;
        o_cmd.wr_row = w_accept && (i_s_tuser == ACT_WRITE);
        o_cmd.start  = w_accept && (i_s_tuser == ACT_QUERY);
        o_cmd.step   = (r_state == ST_RUN) && !i_sts.len_zero;
        o_cmd.emit   = (r_state == ST_DONE) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    r_idx <= '0;
                    if (o_cmd.start) begin
                        r_state <= ST_RUN;
                    end
                end
                ST_RUN: begin
                    if (i_sts.len_zero) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_idx <= w_last ? '0 : r_idx + VW'(1);
                    end
                end
                ST_DONE: begin
                    if (i_sts.out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

[design/wcel_dp.sv]
// datapath: adjacency rows, count vector, per-vertex saturating accumulators
// and the output word register; depends on wcel_pkg
module wcel_dp
    import wcel_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cmd                i_cmd,
    output t_sts                o_sts,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_m_tready,
    output logic                o_m_tvalid,
    output logic [CNT_W-1:0]    o_m_tdata,
    output logic                o_m_tuser
);

    localparam logic [FIELD_VW:0] NV_LIM  = (FIELD_VW + 1)'(NV);
    localparam logic [FIELD_VW:0] LEN_LIM = (FIELD_VW + 1)'(MAX_LEN);

    logic [NV-1:0]       r_adj [NV];
    logic [CNT_W-1:0]    r_cnt [NV];
    logic [CNT_W-1:0]    r_acc [NV];
    logic [FIELD_VW-1:0] r_len;
    logic [FIELD_VW-1:0] r_from;
    logic [CNT_W-1:0]    r_res;
    logic                r_ovf;
    logic                r_out_valid;
    logic [CNT_W-1:0]    r_out_cnt;
    logic                r_out_sat;

    logic [FIELD_VW-1:0] w_row_idx;
    logic [ROW_W-1:0]    w_row_bits;
    logic [FIELD_VW-1:0] w_from;
    logic [FIELD_VW-1:0] w_to;
    logic [FIELD_VW-1:0] w_len_in;
    logic                w_bad;
    logic [FIELD_VW-1:0] w_len_clamp;
    logic [CNT_W-1:0]    w_pick;
    logic [CNT_W:0]      w_sum [NV];
    logic [CNT_W-1:0]    w_sat [NV];
    logic                w_carry;

    assign w_row_idx  = i_s_tdata[ROW_IDX_LSB +: FIELD_VW];
    assign w_row_bits = i_s_tdata[ROW_BITS_LSB +: ROW_W];
    assign w_from     = i_s_tdata[FROM_LSB +: FIELD_VW];
    assign w_to       = i_s_tdata[TO_LSB +: FIELD_VW];
    assign w_len_in   = i_s_tdata[LEN_LSB +: FIELD_VW];

    assign w_bad = ({1'b0, w_from} >= NV_LIM) || ({1'b0, w_to} >= NV_LIM);
    assign w_len_clamp = ({1'b0, w_len_in} > LEN_LIM) ? FIELD_VW'(MAX_LEN) : w_len_in;

    assign w_pick = r_cnt[i_cmd.idx];

    // one successor per cycle, added into every vertex lane at once
    always_comb begin
        w_carry = 1'b0;
        for (int i = 0; i < NV; i++) begin
            w_sum[i] = {1'b0, ((i_cmd.idx == '0) ? '0 : r_acc[i])}
                     + {1'b0, (r_adj[i][i_cmd.idx] ? w_pick : '0)};
            w_sat[i] = w_sum[i][CNT_W] ? '1 : w_sum[i][CNT_W-1:0];
            if (w_sum[i][CNT_W]) begin
                w_carry = 1'b1;
            end
        end
    end

    assign o_sts.len_zero = (r_len == '0);
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NV; i++) begin
                r_adj[i] <= '0;
            end
            r_len       <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_row && ({1'b0, w_row_idx} < NV_LIM)) begin
                r_adj[w_row_idx[VW-1:0]] <= w_row_bits[NV-1:0];
            end
            if (i_cmd.start) begin
                r_ovf <= 1'b0;
                if (w_bad) begin
                    r_len <= '0;
                end else begin
                    r_len <= w_len_clamp;
                end
            end else if (i_cmd.step) begin
                if (w_carry) begin
                    r_ovf <= 1'b1;
                end
                if (i_cmd.last) begin
                    r_len <= r_len - FIELD_VW'(1);
                end
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_from <= w_from;
            r_res  <= (!w_bad && (w_from == w_to)) ? CNT_W'(1) : '0;
            for (int i = 0; i < NV; i++) begin
                r_cnt[i] <= (w_to == FIELD_VW'(i)) ? CNT_W'(1) : '0;
            end
        end else if (i_cmd.step) begin
            for (int i = 0; i < NV; i++) begin
                r_acc[i] <= w_sat[i];
                if (i_cmd.last) begin
                    r_cnt[i] <= w_sat[i];
                end
            end
            if (i_cmd.last) begin
                r_res <= w_sat[r_from[VW-1:0]];
            end
        end
        if (i_cmd.emit) begin
            r_out_cnt <= r_res;
            r_out_sat <= r_ovf;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_cnt;
    assign o_m_tuser  = r_out_sat;

endmodule

[design/walk_count_exact_length_core.sv]
// Exact-length walk counter over a stored 16-vertex directed graph.
// Input stream: tuser low writes one adjacency row (row_index, row_bits),
// tuser high asks for the number of walks from_vertex -> to_vertex with
// exactly walk_length edges. A write gives no output word; a query gives one.
// Output stream: tdata carries the count (saturated at all ones), tuser the
// saturation flag of that query.
// A write is taken and the block is ready again at once.
// A query of length L runs L passes over the 16 successor vertices, one
// successor vertex per cycle added into all 16 vertex accumulators.
// Only one query is in flight; the input is not ready until its word has been
// placed in the output register.
// The output register holds one word; if the receiver stalls, a finished
// query waits until that register frees up, and further writes wait too.
// Reset clears the adjacency matrix (empty graph) and the output valid flag.
// Depends on wcel_pkg, wcel_ctrl and wcel_dp.
module walk_count_exact_length_core
    import wcel_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,  // row_index, row_bits, from_vertex, to_vertex, walk_length
    input  logic                i_s_tuser,  // action
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [CNT_W-1:0]    o_m_tdata,  // walk_count
    output logic                o_m_tuser   // saturated
);

    t_cmd w_cmd;
    t_sts w_sts;

    wcel_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tuser  (i_s_tuser),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wcel_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
